// ===== rtl/i2cm_pkg.sv =====
`timescale 1ns / 1ps

package i2cm_pkg;

  localparam int unsigned ActionW = 3;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned BitCntW = 4;
  localparam int unsigned BitsPerByte = 8;

  localparam logic [ActionW-1:0] ACT_NONE  = 3'd0;
  localparam logic [ActionW-1:0] ACT_START = 3'd1;
  localparam logic [ActionW-1:0] ACT_STOP  = 3'd2;
  localparam logic [ActionW-1:0] ACT_WRITE = 3'd3;
  localparam logic [ActionW-1:0] ACT_RDACK = 3'd4;
  localparam logic [ActionW-1:0] ACT_RDNAK = 3'd5;

  localparam logic [0:0] CFG_SCL_HIGH = 1'd0;
  localparam logic [0:0] CFG_SCL_LOW  = 1'd1;

  localparam logic [ByteW-1:0] SCL_HIGH_RST = 8'd1;
  localparam logic [ByteW-1:0] SCL_LOW_RST  = 8'd2;

  typedef enum logic [10:0] {
    PH_IDLE   = 11'b000_0000_0001,
    PH_ST_PRE = 11'b000_0000_0010,
    PH_ST_HI1 = 11'b000_0000_0100,
    PH_ST_HI2 = 11'b000_0000_1000,
    PH_SP_PRE = 11'b000_0001_0000,
    PH_SP_HI1 = 11'b000_0010_0000,
    PH_SP_HI2 = 11'b000_0100_0000,
    PH_D_LO   = 11'b000_1000_0000,
    PH_D_HI   = 11'b001_0000_0000,
    PH_A_LO   = 11'b010_0000_0000,
    PH_A_HI   = 11'b100_0000_0000
  } phase_e;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [ByteW-1:0]   tx_byte;
    logic               sda_in;
  } in_word_t;

  typedef struct packed {
    logic             scl_out;
    logic             sda_out;
    logic             busy_res;
    logic [ByteW-1:0] rx_byte;
    logic             rx_valid;
    logic             ack_error;
  } out_word_t;

endpackage

// ===== rtl/i2cm_stream_if.sv =====
`timescale 1ns / 1ps

interface i2cm_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/i2c_master_byte_engine.sv =====
`timescale 1ns / 1ps
// Byte-level I2C master, one timebase tick per input word.
// in_i  (sink): action, tx_byte, sda_in for one tick. Actions are taken only
//               when the engine is idle; otherwise they are ignored.
// out_o (source): scl_out/sda_out drive (1 = released), busy_res, rx_byte,
//               rx_valid, ack_error for that tick. One output word per input.
// cfg: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 = SCL high ticks,
//      1 = SCL low ticks); write only while no words are in flight.
// The output word is registered: valid the cycle after input accept.
// Throughput: 1 word per cycle while the output is not stalled; the tick
// update is a single pass from the state registers to the output register.
// A stalled output holds its word; a new input is accepted in the same cycle
// the held word is taken, so back-to-back flow continues.
// Reset: engine idle, both lines released, rx_byte 0, SCL high 1 / low 2.
module i2c_master_byte_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  i2cm_stream_if.sink   in_i,
  i2cm_stream_if.source out_o
);

  i2cm_pkg::phase_e                      phase_q, phase_d, eff_phase;
  logic [i2cm_pkg::ActionW-1:0]          cmd_q, cmd_d;
  logic [i2cm_pkg::BitCntW-1:0]          bit_q, bit_d, bit_inc;
  logic [i2cm_pkg::ByteW-1:0]            shift_q, shift_d;
  logic [i2cm_pkg::ByteW-1:0]            tick_q, tick_d;
  logic                                  scl_lvl_q, scl_lvl_d;
  logic                                  sda_lvl_q, sda_lvl_d;
  logic [i2cm_pkg::ByteW-1:0]            rx_last_q, rx_last_d;
  logic [i2cm_pkg::ByteW-1:0]            scl_high_q, scl_low_q;
  logic                                  out_valid_q;
  i2cm_pkg::out_word_t                   out_q, out_d;

  logic                                  in_acc;
  logic                                  cmd_ok, take_cmd, wr, last, hi_phase;
  logic [i2cm_pkg::ByteW-1:0]            len_sel, len_m1, eff_tick, eff_shift;
  logic [i2cm_pkg::BitCntW-1:0]          eff_bit;
  logic [i2cm_pkg::ActionW-1:0]          eff_cmd, act;
  logic                                  scl_v, sda_v, rxv, aerr;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  assign act    = in_i.data.action;
  assign cmd_ok = (act == i2cm_pkg::ACT_START) || (act == i2cm_pkg::ACT_STOP) ||
                  (act == i2cm_pkg::ACT_WRITE) || (act == i2cm_pkg::ACT_RDACK) ||
                  (act == i2cm_pkg::ACT_RDNAK);
  assign take_cmd = (phase_q == i2cm_pkg::PH_IDLE) && cmd_ok;

  always_comb begin
    eff_phase = phase_q;
    eff_cmd   = cmd_q;
    eff_tick  = tick_q;
    eff_bit   = bit_q;
    eff_shift = shift_q;
    if (take_cmd) begin
      eff_cmd  = act;
      eff_tick = '0;
      eff_bit  = '0;
      case (act)
        i2cm_pkg::ACT_START: eff_phase = i2cm_pkg::PH_ST_PRE;
        i2cm_pkg::ACT_STOP:  eff_phase = i2cm_pkg::PH_SP_PRE;
        default: begin
          eff_phase = i2cm_pkg::PH_D_LO;
          eff_shift = (act == i2cm_pkg::ACT_WRITE) ? in_i.data.tx_byte : '0;
        end
      endcase
    end
  end

  assign wr       = (eff_cmd == i2cm_pkg::ACT_WRITE);
  assign hi_phase = (eff_phase == i2cm_pkg::PH_ST_HI1) || (eff_phase == i2cm_pkg::PH_ST_HI2) ||
                    (eff_phase == i2cm_pkg::PH_SP_HI1) || (eff_phase == i2cm_pkg::PH_SP_HI2) ||
                    (eff_phase == i2cm_pkg::PH_D_HI)   || (eff_phase == i2cm_pkg::PH_A_HI);
  assign len_sel  = hi_phase ? scl_high_q : scl_low_q;
  assign len_m1   = (len_sel == '0) ? '0 : len_sel - 8'd1;
  assign last     = (eff_tick >= len_m1);
  assign bit_inc  = eff_bit + 4'd1;

  always_comb begin
    phase_d   = eff_phase;
    cmd_d     = eff_cmd;
    bit_d     = eff_bit;
    shift_d   = eff_shift;
    tick_d    = eff_tick;
    scl_lvl_d = scl_lvl_q;
    sda_lvl_d = sda_lvl_q;
    rx_last_d = rx_last_q;
    scl_v     = scl_lvl_q;
    sda_v     = sda_lvl_q;
    rxv       = 1'b0;
    aerr      = 1'b0;
    if (eff_phase != i2cm_pkg::PH_IDLE) begin
      case (eff_phase)
        i2cm_pkg::PH_ST_PRE: begin scl_v = scl_lvl_q; sda_v = 1'b1; end
        i2cm_pkg::PH_ST_HI1: begin scl_v = 1'b1; sda_v = 1'b1; end
        i2cm_pkg::PH_ST_HI2: begin scl_v = 1'b1; sda_v = 1'b0; end
        i2cm_pkg::PH_SP_PRE: begin scl_v = scl_lvl_q; sda_v = 1'b0; end
        i2cm_pkg::PH_SP_HI1: begin scl_v = 1'b1; sda_v = 1'b0; end
        i2cm_pkg::PH_SP_HI2: begin scl_v = 1'b1; sda_v = 1'b1; end
        i2cm_pkg::PH_D_LO, i2cm_pkg::PH_D_HI: begin
          scl_v = (eff_phase == i2cm_pkg::PH_D_HI);
          sda_v = wr ? eff_shift[i2cm_pkg::ByteW-1] : 1'b1;
        end
        default: begin
          scl_v = (eff_phase == i2cm_pkg::PH_A_HI);
          sda_v = wr ? 1'b1 : (eff_cmd != i2cm_pkg::ACT_RDACK);
        end
      endcase
      scl_lvl_d = scl_v;
      sda_lvl_d = sda_v;
      if (!last) begin
        tick_d = eff_tick + 8'd1;
      end else begin
        tick_d = '0;
        case (eff_phase)
          i2cm_pkg::PH_ST_PRE: phase_d = i2cm_pkg::PH_ST_HI1;
          i2cm_pkg::PH_ST_HI1: phase_d = i2cm_pkg::PH_ST_HI2;
          i2cm_pkg::PH_ST_HI2: begin
            phase_d   = i2cm_pkg::PH_IDLE;
            scl_lvl_d = 1'b0;
            sda_lvl_d = 1'b0;
          end
          i2cm_pkg::PH_SP_PRE: phase_d = i2cm_pkg::PH_SP_HI1;
          i2cm_pkg::PH_SP_HI1: phase_d = i2cm_pkg::PH_SP_HI2;
          i2cm_pkg::PH_SP_HI2: phase_d = i2cm_pkg::PH_IDLE;
          i2cm_pkg::PH_D_LO:   phase_d = i2cm_pkg::PH_D_HI;
          i2cm_pkg::PH_D_HI: begin
            shift_d = {eff_shift[i2cm_pkg::ByteW-2:0], wr ? 1'b0 : in_i.data.sda_in};
            bit_d   = bit_inc;
            phase_d = (bit_inc >= 4'(i2cm_pkg::BitsPerByte)) ? i2cm_pkg::PH_A_LO
                                                             : i2cm_pkg::PH_D_LO;
          end
          i2cm_pkg::PH_A_LO:   phase_d = i2cm_pkg::PH_A_HI;
          default: begin
            if (wr) begin
              aerr = in_i.data.sda_in;
            end else begin
              rx_last_d = eff_shift;
              rxv       = 1'b1;
            end
            phase_d   = i2cm_pkg::PH_IDLE;
            scl_lvl_d = 1'b0;
          end
        endcase
      end
    end
    out_d.scl_out   = scl_v;
    out_d.sda_out   = sda_v;
    out_d.busy_res  = (eff_phase != i2cm_pkg::PH_IDLE);
    out_d.rx_byte   = rx_last_d;
    out_d.rx_valid  = rxv;
    out_d.ack_error = aerr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= i2cm_pkg::PH_IDLE;
      cmd_q       <= i2cm_pkg::ACT_NONE;
      bit_q       <= '0;
      shift_q     <= '0;
      tick_q      <= '0;
      scl_lvl_q   <= 1'b1;
      sda_lvl_q   <= 1'b1;
      rx_last_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_q   <= phase_d;
        cmd_q     <= cmd_d;
        bit_q     <= bit_d;
        shift_q   <= shift_d;
        tick_q    <= tick_d;
        scl_lvl_q <= scl_lvl_d;
        sda_lvl_q <= sda_lvl_d;
        rx_last_q <= rx_last_d;
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scl_high_q <= i2cm_pkg::SCL_HIGH_RST;
      scl_low_q  <= i2cm_pkg::SCL_LOW_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        i2cm_pkg::CFG_SCL_HIGH: scl_high_q <= cfg_data_i;
        i2cm_pkg::CFG_SCL_LOW:  scl_low_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q <= out_d;
    end
  end

`ifndef ASSERT_OFF
  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q)) else $error("phase register not one-hot");

  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_q <= 4'(i2cm_pkg::BitsPerByte)) else $error("bit counter overran");

  a_excl_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.rx_valid && out_q.ack_error))
    else $error("read and write completion in one word");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && phase_q == i2cm_pkg::PH_IDLE && !cmd_ok) |=>
      (phase_q == i2cm_pkg::PH_IDLE && !out_q.busy_res))
    else $error("engine left idle without a command");

  a_busy_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && phase_q != i2cm_pkg::PH_IDLE) |=> out_q.busy_res)
    else $error("busy dropped during a command");
`endif

endmodule

// ===== tb/sv/i2cm_drive_checker.sv =====
`timescale 1ns / 1ps

module i2cm_drive_checker import i2cm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        tick_valid_i,
  input  logic        tick_ready_i,
  input  in_word_t    tick_i,
  input  logic        drive_valid_i,
  input  logic        drive_ready_i,
  input  out_word_t   drive_i,
  output int unsigned err_cnt_o,
  output int unsigned pend_cnt_o
);

  logic [ByteW-1:0]   hi_ticks_q;
  logic [ByteW-1:0]   lo_ticks_q;
  phase_e             ph_q;
  logic [ActionW-1:0] cmd_q;
  logic [BitCntW-1:0] nbit_q;
  logic [ByteW-1:0]   shreg_q;
  logic [ByteW-1:0]   tcnt_q;
  logic               scl_q;
  logic               sda_q;
  logic [ByteW-1:0]   rx_q;

  out_word_t   drive_exp_q[$];
  int unsigned err_q  = 0;
  int unsigned pend_q = 0;

  assign err_cnt_o  = err_q;
  assign pend_cnt_o = pend_q;

  task automatic report_bad(string fld, logic [7:0] got, logic [7:0] want);
    if (err_q < 50) begin
      $display("%0t: %s mismatch, got %0h want %0h", $time, fld, got, want);
    end
    err_q++;
  endtask

  // a zero count behaves as one
  function automatic int span_of(phase_e p);
    logic [ByteW-1:0] n;
    case (p)
      PH_ST_HI1, PH_ST_HI2, PH_SP_HI1, PH_SP_HI2, PH_D_HI, PH_A_HI: n = hi_ticks_q;
      default: n = lo_ticks_q;
    endcase
    return (n == '0) ? 1 : int'(n);
  endfunction

  function automatic out_word_t bus_tick(in_word_t w);
    out_word_t o;
    logic      wr;
    logic      last;
    o = '0;
    o.scl_out = scl_q;
    o.sda_out = sda_q;
    if (ph_q == PH_IDLE && w.action >= ACT_START && w.action <= ACT_RDNAK) begin
      cmd_q  = w.action;
      tcnt_q = '0;
      nbit_q = '0;
      case (w.action)
        ACT_START: ph_q = PH_ST_PRE;
        ACT_STOP:  ph_q = PH_SP_PRE;
        default: begin
          ph_q    = PH_D_LO;
          shreg_q = (w.action == ACT_WRITE) ? w.tx_byte : '0;
        end
      endcase
    end
    if (ph_q != PH_IDLE) begin
      wr   = (cmd_q == ACT_WRITE);
      last = (int'(tcnt_q) + 1 >= span_of(ph_q));
      o.busy_res = 1'b1;
      case (ph_q)
        PH_ST_PRE: o.sda_out = 1'b1;
        PH_ST_HI1: begin o.scl_out = 1'b1; o.sda_out = 1'b1; end
        PH_ST_HI2: begin o.scl_out = 1'b1; o.sda_out = 1'b0; end
        PH_SP_PRE: o.sda_out = 1'b0;
        PH_SP_HI1: begin o.scl_out = 1'b1; o.sda_out = 1'b0; end
        PH_SP_HI2: begin o.scl_out = 1'b1; o.sda_out = 1'b1; end
        PH_D_LO, PH_D_HI: begin
          o.scl_out = (ph_q == PH_D_HI);
          o.sda_out = wr ? shreg_q[ByteW-1] : 1'b1;
        end
        default: begin
          o.scl_out = (ph_q == PH_A_HI);
          o.sda_out = wr ? 1'b1 : (cmd_q != ACT_RDACK);
        end
      endcase
      scl_q = o.scl_out;
      sda_q = o.sda_out;
      if (!last) begin
        tcnt_q = tcnt_q + 8'd1;
      end else begin
        tcnt_q = '0;
        case (ph_q)
          PH_ST_PRE: ph_q = PH_ST_HI1;
          PH_ST_HI1: ph_q = PH_ST_HI2;
          PH_ST_HI2: begin
            ph_q  = PH_IDLE;
            scl_q = 1'b0;
            sda_q = 1'b0;
          end
          PH_SP_PRE: ph_q = PH_SP_HI1;
          PH_SP_HI1: ph_q = PH_SP_HI2;
          PH_SP_HI2: ph_q = PH_IDLE;
          PH_D_LO:   ph_q = PH_D_HI;
          PH_D_HI: begin
            shreg_q = {shreg_q[ByteW-2:0], wr ? 1'b0 : w.sda_in};
            nbit_q  = nbit_q + 4'd1;
            ph_q    = (nbit_q >= BitCntW'(BitsPerByte)) ? PH_A_LO : PH_D_LO;
          end
          PH_A_LO:   ph_q = PH_A_HI;
          default: begin
            if (wr) begin
              o.ack_error = w.sda_in;
            end else begin
              rx_q       = shreg_q;
              o.rx_valid = 1'b1;
            end
            ph_q  = PH_IDLE;
            scl_q = 1'b0;
          end
        endcase
      end
    end
    o.rx_byte = rx_q;
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      hi_ticks_q = SCL_HIGH_RST;
      lo_ticks_q = SCL_LOW_RST;
      ph_q       = PH_IDLE;
      cmd_q      = ACT_NONE;
      nbit_q     = '0;
      shreg_q    = '0;
      tcnt_q     = '0;
      scl_q      = 1'b1;
      sda_q      = 1'b1;
      rx_q       = '0;
      drive_exp_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_SCL_HIGH) hi_ticks_q = cfg_data_i;
        else lo_ticks_q = cfg_data_i;
      end
      if (drive_valid_i && drive_ready_i) begin
        if (drive_exp_q.size() == 0) begin
          report_bad("unexpected word", '0, '0);
        end else begin
          want = drive_exp_q.pop_front();
          if (drive_i.scl_out !== want.scl_out)
            report_bad("scl_out", 8'(drive_i.scl_out), 8'(want.scl_out));
          if (drive_i.sda_out !== want.sda_out)
            report_bad("sda_out", 8'(drive_i.sda_out), 8'(want.sda_out));
          if (drive_i.busy_res !== want.busy_res)
            report_bad("busy_res", 8'(drive_i.busy_res), 8'(want.busy_res));
          if (drive_i.rx_byte !== want.rx_byte)
            report_bad("rx_byte", drive_i.rx_byte, want.rx_byte);
          if (drive_i.rx_valid !== want.rx_valid)
            report_bad("rx_valid", 8'(drive_i.rx_valid), 8'(want.rx_valid));
          if (drive_i.ack_error !== want.ack_error)
            report_bad("ack_error", 8'(drive_i.ack_error), 8'(want.ack_error));
        end
      end
      if (tick_valid_i && tick_ready_i) begin
        drive_exp_q.push_back(bus_tick(tick_i));
      end
    end
    pend_q = drive_exp_q.size();
  end

endmodule

// ===== tb/sv/tb_i2c_master_byte_engine.sv =====
`timescale 1ns / 1ps

module tb_i2c_master_byte_engine;
  import i2cm_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldCycles = 300;

  logic       clk_i    = 1'b0;
  logic       rst_ni   = 1'b0;
  logic       cfg_we   = 1'b0;
  logic [0:0] cfg_idx  = CFG_SCL_HIGH;
  logic [7:0] cfg_data = '0;

  logic [ByteW-1:0] hi_ticks = SCL_HIGH_RST;
  logic [ByteW-1:0] lo_ticks = SCL_LOW_RST;

  int unsigned tx_idle_pct = 30;
  int unsigned rx_idle_pct = 60;
  bit          hold_req    = 1'b0;
  int unsigned quiet_cnt   = 0;
  int unsigned err_cnt;
  int unsigned pend_cnt;

  i2cm_stream_if #(.T(in_word_t))  tick_if ();
  i2cm_stream_if #(.T(out_word_t)) drive_if ();

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  i2c_master_byte_engine i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (tick_if),
    .out_o      (drive_if)
  );

  i2cm_drive_checker i_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .tick_valid_i  (tick_if.valid),
    .tick_ready_i  (tick_if.ready),
    .tick_i        (tick_if.data),
    .drive_valid_i (drive_if.valid),
    .drive_ready_i (drive_if.ready),
    .drive_i       (drive_if.data),
    .err_cnt_o     (err_cnt),
    .pend_cnt_o    (pend_cnt)
  );

  always @(posedge clk_i) begin
    if (!rst_ni || (tick_if.valid && tick_if.ready) || (drive_if.valid && drive_if.ready)) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    drive_if.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        drive_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      drive_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic put_tick(logic [2:0] act, logic [7:0] txb, logic sdi);
    bit hs;
    while ($urandom_range(99) < tx_idle_pct) begin
      tick_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    tick_if.valid <= 1'b1;
    tick_if.data  <= '{action: act, tx_byte: txb, sda_in: sdi};
    do begin
      @(negedge clk_i);
      hs = tick_if.ready;
      @(posedge clk_i);
    end while (!hs);
  endtask

  // one command word, then filler words until the engine is idle again;
  // fillers carry random actions that must be ignored while busy
  task automatic run_cmd(logic [2:0] act, logic [7:0] txb, logic [7:0] rxb, logic ack);
    int unsigned hi;
    int unsigned lo;
    int unsigned n_ticks;
    int unsigned bit_idx;
    int unsigned t;
    logic        sdi;
    logic [2:0]  a;
    hi = (hi_ticks == '0) ? 1 : int'(hi_ticks);
    lo = (lo_ticks == '0) ? 1 : int'(lo_ticks);
    case (act)
      ACT_START, ACT_STOP:           n_ticks = lo + 2 * hi;
      ACT_WRITE, ACT_RDACK, ACT_RDNAK: n_ticks = BitsPerByte * (hi + lo) + hi + lo;
      default:                       n_ticks = 1;
    endcase
    for (t = 0; t < n_ticks; t++) begin
      bit_idx = t / (hi + lo);
      if (act < ACT_WRITE || act > ACT_RDNAK) sdi = 1'($urandom_range(1));
      else if (bit_idx < BitsPerByte) sdi = rxb[7 - bit_idx];
      else sdi = ack;
      if (t == 0) a = act;
      else a = $urandom_range(1) ? 3'($urandom_range(7)) : ACT_NONE;
      put_tick(a, (t == 0) ? txb : 8'($urandom), sdi);
    end
  endtask

  task automatic set_timing(logic [7:0] hi, logic [7:0] lo);
    tick_if.valid <= 1'b0;
    @(negedge clk_i);
    wait (pend_cnt == 0);
    repeat (4) @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_SCL_HIGH;
    cfg_data <= hi;
    @(posedge clk_i);
    cfg_idx  <= CFG_SCL_LOW;
    cfg_data <= lo;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    hi_ticks = hi;
    lo_ticks = lo;
  endtask

  task automatic run_random(int unsigned n_cmds);
    int unsigned done_cmds;
    int unsigned n_data;
    int unsigned i;
    logic [2:0]  act;
    done_cmds = 0;
    while (done_cmds < n_cmds) begin
      if ($urandom_range(99) < 80) begin
        // transfer: start, address, data bytes, mostly a stop
        run_cmd(ACT_START, 8'($urandom), 8'($urandom), 1'b0);
        run_cmd(ACT_WRITE, 8'($urandom), 8'($urandom), ($urandom_range(9) == 0));
        n_data = $urandom_range(1, 4);
        for (i = 0; i < n_data; i++) begin
          case ($urandom_range(2))
            0:       act = ACT_WRITE;
            1:       act = ACT_RDACK;
            default: act = ACT_RDNAK;
          endcase
          run_cmd(act, 8'($urandom), 8'($urandom), ($urandom_range(9) == 0));
        end
        done_cmds += n_data + 2;
        if ($urandom_range(4) != 0) begin
          run_cmd(ACT_STOP, 8'($urandom), 8'($urandom), 1'b0);
          done_cmds++;
        end
      end else begin
        act = 3'($urandom_range(7));
        run_cmd(act, 8'($urandom), 8'($urandom), 1'($urandom_range(1)));
        if (act >= ACT_START && act <= ACT_RDNAK) done_cmds++;
      end
    end
  endtask

  initial begin
    tick_if.valid = 1'b0;
    tick_if.data  = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset timing, bus released
    run_cmd(ACT_NONE, 8'hFF, 8'h00, 1'b0);
    run_cmd(3'd6, 8'h00, 8'h00, 1'b0);
    run_cmd(3'd7, 8'hFF, 8'h00, 1'b0);
    run_cmd(ACT_STOP, 8'h00, 8'h00, 1'b0);
    run_cmd(ACT_WRITE, 8'hA5, 8'h00, 1'b0);
    run_cmd(ACT_START, 8'h00, 8'h00, 1'b0);
    run_cmd(ACT_WRITE, 8'h00, 8'hFF, 1'b1);
    run_cmd(ACT_WRITE, 8'hFF, 8'h00, 1'b0);
    run_cmd(ACT_RDACK, 8'h00, 8'hFF, 1'b0);
    run_cmd(ACT_RDNAK, 8'hFF, 8'h00, 1'b1);
    run_cmd(ACT_START, 8'h00, 8'h00, 1'b0);
    run_cmd(ACT_WRITE, 8'h80, 8'h01, 1'b1);
    run_cmd(ACT_RDACK, 8'h00, 8'h5A, 1'b0);
    run_cmd(ACT_RDNAK, 8'h00, 8'hC3, 1'b1);
    run_cmd(ACT_STOP, 8'h00, 8'h00, 1'b0);
    run_cmd(ACT_STOP, 8'h00, 8'h00, 1'b0);
    run_cmd(ACT_START, 8'h00, 8'h00, 1'b0);
    run_cmd(ACT_RDACK, 8'h00, 8'h01, 1'b0);
    run_cmd(ACT_STOP, 8'h00, 8'h00, 1'b0);
    run_cmd(ACT_NONE, 8'h00, 8'h00, 1'b0);
    run_random(12);

    set_timing(8'd0, 8'd0);
    run_random(25);

    set_timing(8'd1, 8'd255);
    run_cmd(ACT_START, 8'h00, 8'h00, 1'b0);

    tx_idle_pct = 60;
    rx_idle_pct = 30;
    set_timing(8'd3, 8'd1);
    hold_req = 1'b1;
    run_random(8);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_timing(8'd2, 8'd7);
    run_random(4);

    set_timing(8'd1, 8'd1);
    run_random(12);

    tick_if.valid <= 1'b0;
    @(negedge clk_i);
    wait (pend_cnt == 0);
    repeat (4) @(posedge clk_i);
    if (err_cnt == 0 && pend_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/i2cm_pkg.sv
rtl/i2cm_stream_if.sv
rtl/i2c_master_byte_engine.sv
tb/sv/i2cm_drive_checker.sv
tb/sv/tb_i2c_master_byte_engine.sv
